// ----- rtl/core/buffer_pool_best_fit_allocator_assert.svh -----
// Assertion macros shared by the pool allocator modules.
// Each one samples on the rising edge of clock and is disabled in reset.
`ifndef BUFFER_POOL_BEST_FIT_ALLOCATOR_ASSERT_SVH
`define BUFFER_POOL_BEST_FIT_ALLOCATOR_ASSERT_SVH

// Condition that holds at every edge.
`define BPBFA_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequence in the same cycle.
`define BPBFA_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequence in the next cycle.
`define BPBFA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/bpbfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bpbfa_pkg;

   localparam int CMD_W      = 3;
   localparam int SIZE_W     = 32;
   localparam int HANDLE_W   = 4;
   localparam int STATUS_W   = 2;
   localparam int TOTAL_W    = 5;
   localparam int TIME_W     = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TICK    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_REUSED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NEW    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OTHER  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DROP_EN = 1'd1;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [SIZE_W-1:0]   request_size;
      logic [HANDLE_W-1:0] slot_handle;
   } req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] granted_slot;
      logic [SIZE_W-1:0]   granted_size;
      logic [STATUS_W-1:0] status;
      logic                slot_busy_flag;
      logic [TOTAL_W-1:0]  busy_total;
      logic [TOTAL_W-1:0]  dropped_total;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic rd_handle;
      logic exec;
      logic scan_rd;
      logic claim;
      logic sweep_rd;
      logic load_out;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_alloc;
      logic scan_last;
      logic best_found;
      logic empty_found;
      logic sweep_due;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// ----- rtl/core/buffer_pool_best_fit_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Best-fit buffer pool allocator with idle aging over POOL_SLOTS slots.
// req_*: valid/ready channel, one beat per command (allocate, release, query,
//   tick, clear). rsp_*: valid/ready channel, exactly one beat per request.
// csr_*: write-only registers; the user must see that they are written only while
//   the block is idle, as the block does not enforce it: index 0 cleanup timeout
//   (also restarts the sweep timer and enables aging), index 1 aging enable.
// One request is in flight at a time. A release, query, tick or clear passes
// through decode, execute and respond; an allocate passes through decode, a
// size scan over all slots, claim and respond, and an allocate that claims a
// new slot while a sweep is due also runs an aging sweep over all slots before
// respond. Sizes and idle stamps sit in single-read-port stores, read one slot
// per cycle.
// Results go through an output register, so a new request is taken while the
// previous response beat still waits; if the receiver stalls, the next
// response holds in the datapath until the output register frees up.
// Synchronous reset empties the pool and zeroes time, timeout and counters.
module buffer_pool_best_fit_allocator import bpbfa_pkg::*; #(
   parameter int POOL_SLOTS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer: decode, scan, claim, sweep, respond
   bpbfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // slot state, stores, compare units and output register
   bpbfa_dp #(
      .POOL_SLOTS (POOL_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

`default_nettype wire

// ----- rtl/core/bpbfa_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "buffer_pool_best_fit_allocator_assert.svh"

module bpbfa_dp import bpbfa_pkg::*; #(
   parameter int POOL_SLOTS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_type               req_data,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire dp_cmd_type            cmd,
   output dp_stat_type                stat
);

   localparam int IW  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int AW  = (IW > HANDLE_W) ? IW : HANDLE_W;
   localparam int CW  = $clog2(POOL_SLOTS + 1);
   localparam int CXW = (CW > TOTAL_W) ? CW : TOTAL_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(POOL_SLOTS - 1);

   // slot storage
   logic [SIZE_W-1:0] size_mem [POOL_SLOTS];
   logic [TIME_W-1:0] idle_mem [POOL_SLOTS];
   logic [SIZE_W-1:0] size_q_ff;
   logic [TIME_W-1:0] idle_q_ff;

   logic [POOL_SLOTS-1:0] valid_ff, valid_in, busy_ff, busy_in;
   logic [CW-1:0]         busy_cnt_ff, busy_cnt_in, drop_cnt_ff, drop_cnt_in;

   req_type            lat_ff;
   logic [IW-1:0]      scan_idx_ff, scan_idx_in;
   logic               cmp_pend_ff, sw_pend_ff;
   logic [IW-1:0]      cmp_idx_ff, sw_idx_ff;

   logic               best_found_ff, best_found_in, empty_found_ff, empty_found_in;
   logic [IW-1:0]      best_idx_ff, best_idx_in, empty_idx_ff, empty_idx_in;
   logic [SIZE_W-1:0]  best_size_ff, best_size_in;

   logic [TIME_W-1:0]  time_ff, time_in, last_sweep_ff, last_sweep_in;
   logic [TIME_W-1:0]  timeout_ff, timeout_in;
   logic               drop_en_ff, drop_en_in;

   logic [HANDLE_W-1:0] res_slot_ff, res_slot_in;
   logic [SIZE_W-1:0]   res_size_ff, res_size_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                res_flag_ff, res_flag_in;

   rsp_type rsp_data_ff, rsp_data_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // addressing and compares
   logic [AW-1:0]     handle_ext, best_ext, empty_ext;
   logic [IW-1:0]     handle_addr, size_ra;
   logic              in_range, hit_valid, hit_busy;
   logic              size_re, size_we, idle_we;
   logic              cand, empty_hit, stale;
   logic [TIME_W-1:0] age, since_sweep;
   logic              sweep_due;
   logic [CXW-1:0]    busy_ext, drop_ext;

   assign handle_ext  = AW'(lat_ff.slot_handle);
   assign handle_addr = handle_ext[IW-1:0];
   assign best_ext    = AW'(best_idx_ff);
   assign empty_ext   = AW'(empty_idx_ff);
   assign in_range    = 32'(lat_ff.slot_handle) < 32'(POOL_SLOTS);
   assign hit_valid   = in_range && valid_ff[handle_addr];
   assign hit_busy    = hit_valid && busy_ff[handle_addr];

   assign size_re = cmd.scan_rd || cmd.rd_handle;
   assign size_ra = cmd.scan_rd ? scan_idx_ff : handle_addr;
   assign size_we = cmd.claim && !best_found_ff && empty_found_ff;
   assign idle_we = cmd.exec && (lat_ff.command == CMD_RELEASE) && hit_busy;

   assign cand = cmp_pend_ff && valid_ff[cmp_idx_ff] && !busy_ff[cmp_idx_ff]
                 && (size_q_ff >= lat_ff.request_size)
                 && (!best_found_ff || (size_q_ff < best_size_ff));
   assign empty_hit = cmp_pend_ff && !valid_ff[cmp_idx_ff] && !empty_found_ff;

   assign age         = time_ff - idle_q_ff;
   assign stale       = sw_pend_ff && valid_ff[sw_idx_ff] && !busy_ff[sw_idx_ff]
                        && (age > timeout_ff);
   assign since_sweep = time_ff - last_sweep_ff;
   assign sweep_due   = drop_en_ff && (timeout_ff != '0) && (since_sweep > timeout_ff);

   assign busy_ext = CXW'(busy_cnt_ff);
   assign drop_ext = CXW'(drop_cnt_ff);

   always_comb begin
      valid_in       = valid_ff;
      busy_in        = busy_ff;
      busy_cnt_in    = busy_cnt_ff;
      drop_cnt_in    = drop_cnt_ff;
      scan_idx_in    = scan_idx_ff;
      best_found_in  = best_found_ff;
      best_idx_in    = best_idx_ff;
      best_size_in   = best_size_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      time_in        = time_ff;
      last_sweep_in  = last_sweep_ff;
      timeout_in     = timeout_ff;
      drop_en_in     = drop_en_ff;
      res_slot_in    = res_slot_ff;
      res_size_in    = res_size_ff;
      res_status_in  = res_status_ff;
      res_flag_in    = res_flag_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff;

      if (cmd.accept) begin
         scan_idx_in    = '0;
         best_found_in  = 1'b0;
         empty_found_in = 1'b0;
         drop_cnt_in    = '0;
      end

      if (cmd.scan_rd || cmd.sweep_rd) begin
         scan_idx_in = scan_idx_ff + IW'(1);
      end

      if (cand) begin
         best_found_in = 1'b1;
         best_idx_in   = cmp_idx_ff;
         best_size_in  = size_q_ff;
      end
      if (empty_hit) begin
         empty_found_in = 1'b1;
         empty_idx_in   = cmp_idx_ff;
      end

      // aging sweep: drop idle free slots
      if (stale) begin
         valid_in[sw_idx_ff] = 1'b0;
         drop_cnt_in         = drop_cnt_ff + CW'(1);
      end

      if (cmd.claim) begin
         scan_idx_in = '0;
         res_flag_in = 1'b0;
         if (best_found_ff) begin
            busy_in[best_idx_ff] = 1'b1;
            busy_cnt_in          = busy_cnt_ff + CW'(1);
            res_slot_in          = best_ext[HANDLE_W-1:0];
            res_size_in          = best_size_ff;
            res_status_in        = ST_REUSED;
         end else if (empty_found_ff) begin
            valid_in[empty_idx_ff] = 1'b1;
            busy_in[empty_idx_ff]  = 1'b1;
            busy_cnt_in            = busy_cnt_ff + CW'(1);
            res_slot_in            = empty_ext[HANDLE_W-1:0];
            res_size_in            = lat_ff.request_size;
            res_status_in          = ST_NEW;
            if (sweep_due) begin
               last_sweep_in = time_ff;
            end
         end else begin
            res_slot_in   = '0;
            res_size_in   = '0;
            res_status_in = ST_FULL;
         end
      end

      if (cmd.exec) begin
         res_slot_in   = lat_ff.slot_handle;
         res_size_in   = hit_valid ? size_q_ff : '0;
         res_status_in = ST_OTHER;
         res_flag_in   = 1'b0;
         case (lat_ff.command)
            CMD_RELEASE: begin
               if (hit_busy) begin
                  busy_in[handle_addr] = 1'b0;
                  if (busy_cnt_ff != '0) begin
                     busy_cnt_in = busy_cnt_ff - CW'(1);
                  end
               end
            end
            CMD_QUERY: begin
               res_flag_in = hit_busy;
            end
            CMD_TICK: begin
               time_in = time_ff + TIME_W'(1);
            end
            CMD_CLEAR: begin
               valid_in    = '0;
               busy_in     = '0;
               busy_cnt_in = '0;
               drop_en_in  = 1'b0;
               res_size_in = '0;
            end
            default: begin
            end
         endcase
      end

      if (csr_we) begin
         case (csr_index)
            REG_TIMEOUT: begin
               timeout_in    = csr_wdata[TIME_W-1:0];
               last_sweep_in = time_ff;
               drop_en_in    = 1'b1;
            end
            REG_DROP_EN: begin
               drop_en_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end

      if (cmd.load_out) begin
         rsp_data_in.granted_slot   = res_slot_ff;
         rsp_data_in.granted_size   = res_size_ff;
         rsp_data_in.status         = res_status_ff;
         rsp_data_in.slot_busy_flag = res_flag_ff;
         rsp_data_in.busy_total     = busy_ext[TOTAL_W-1:0];
         rsp_data_in.dropped_total  = drop_ext[TOTAL_W-1:0];
         rsp_valid_in               = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         busy_ff        <= '0;
         busy_cnt_ff    <= '0;
         drop_cnt_ff    <= '0;
         scan_idx_ff    <= '0;
         cmp_pend_ff    <= 1'b0;
         sw_pend_ff     <= 1'b0;
         best_found_ff  <= 1'b0;
         empty_found_ff <= 1'b0;
         time_ff        <= '0;
         last_sweep_ff  <= '0;
         timeout_ff     <= '0;
         drop_en_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         busy_ff        <= busy_in;
         busy_cnt_ff    <= busy_cnt_in;
         drop_cnt_ff    <= drop_cnt_in;
         scan_idx_ff    <= scan_idx_in;
         cmp_pend_ff    <= cmd.scan_rd;
         sw_pend_ff     <= cmd.sweep_rd;
         best_found_ff  <= best_found_in;
         empty_found_ff <= empty_found_in;
         time_ff        <= time_in;
         last_sweep_ff  <= last_sweep_in;
         timeout_ff     <= timeout_in;
         drop_en_ff     <= drop_en_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         lat_ff <= req_data;
      end
      cmp_idx_ff    <= scan_idx_ff;
      sw_idx_ff     <= scan_idx_ff;
      best_idx_ff   <= best_idx_in;
      best_size_ff  <= best_size_in;
      empty_idx_ff  <= empty_idx_in;
      res_slot_ff   <= res_slot_in;
      res_size_ff   <= res_size_in;
      res_status_ff <= res_status_in;
      res_flag_ff   <= res_flag_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // size store: one write, one registered read
   always_ff @(posedge clock) begin
      if (size_we) begin
         size_mem[empty_idx_ff] <= lat_ff.request_size;
      end
      if (size_re) begin
         size_q_ff <= size_mem[size_ra];
      end
   end

   // idle stamp store
   always_ff @(posedge clock) begin
      if (idle_we) begin
         idle_mem[handle_addr] <= time_ff;
      end
      if (cmd.sweep_rd) begin
         idle_q_ff <= idle_mem[scan_idx_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign stat.is_alloc    = lat_ff.command == CMD_ALLOC;
   assign stat.scan_last   = scan_idx_ff == LAST_IDX;
   assign stat.best_found  = best_found_ff;
   assign stat.empty_found = empty_found_ff;
   assign stat.sweep_due   = sweep_due;
   assign stat.out_free    = !rsp_valid_ff || rsp_ready;

   `BPBFA_ASSERT_ALWAYS(a_busy_in_valid, ((busy_ff & ~valid_ff) == '0), "busy slot is not valid")
   `BPBFA_ASSERT_ALWAYS(a_busy_count, ($countones(busy_ff) == int'(busy_cnt_ff)), "busy count drift")
   `BPBFA_ASSERT_IMPLY(a_claim_drained, cmd.claim, (!cmp_pend_ff && !cmd.scan_rd), "claim before scan done")

endmodule

`default_nettype wire

// ----- rtl/core/bpbfa_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "buffer_pool_best_fit_allocator_assert.svh"

module bpbfa_ctrl import bpbfa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_DECODE    = 9'b000000010,
      S_EXEC      = 9'b000000100,
      S_SCAN      = 9'b000001000,
      S_SCAN_END  = 9'b000010000,
      S_CLAIM     = 9'b000100000,
      S_SWEEP     = 9'b001000000,
      S_SWEEP_END = 9'b010000000,
      S_RESP      = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.is_alloc) begin
               state_in = S_SCAN;
            end else begin
               cmd.rd_handle = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_RESP;
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (stat.scan_last) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            // let the last compare land
            state_in = S_CLAIM;
         end
         S_CLAIM: begin
            cmd.claim = 1'b1;
            if (!stat.best_found && stat.empty_found && stat.sweep_due) begin
               state_in = S_SWEEP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SWEEP: begin
            cmd.sweep_rd = 1'b1;
            if (stat.scan_last) begin
               state_in = S_SWEEP_END;
            end
         end
         S_SWEEP_END: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `BPBFA_ASSERT_NEXT(a_accept_decode, (req_valid && req_ready), (state_ff == S_DECODE), "accept did not decode")
   `BPBFA_ASSERT_IMPLY(a_load_free, cmd.load_out, stat.out_free, "result overwrote waiting beat")
   `BPBFA_ASSERT_IMPLY(a_exec_not_alloc, cmd.exec, !stat.is_alloc, "allocate took the handle path")

endmodule

`default_nettype wire

// ----- verif/buffer_pool_best_fit_allocator_tb.sv -----
`timescale 1ns / 1ps

module buffer_pool_best_fit_allocator_tb;
   import bpbfa_pkg::*;

   localparam int POOL_SLOTS = 16;

   // Command codes the block must treat as no-ops.
   localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

   localparam int PHASES         = 12;
   localparam int PHASE_ITEMS    = 128;
   localparam int DRAIN_CYCLES   = 4;
   localparam int SETTLE_CYCLES  = 40;   // longer than the longest allocate, one with an aging sweep
   localparam int TIMEOUT_NS     = 8_000_000;

   // ------------------------------------------------------------------
   // Shadow of the pool: tracks slots, time and aging registers and keeps
   // the response beats still owed by the block, oldest first.
   // ------------------------------------------------------------------
   class pool_shadow;
      bit          slot_valid [POOL_SLOTS];
      bit          slot_busy  [POOL_SLOTS];
      bit [31:0]   slot_size  [POOL_SLOTS];
      bit [31:0]   idle_since [POOL_SLOTS];
      bit [31:0]   now_sec;
      bit [31:0]   last_sweep;
      bit [31:0]   idle_limit;
      bit          aging_en;
      int unsigned busy_count;
      rsp_type     owed_grants [$];
      int          errors;

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == REG_TIMEOUT) begin
            idle_limit = data;
            last_sweep = now_sec;
            aging_en   = 1'b1;
         end else if (idx == REG_DROP_EN) begin
            aging_en = data[0];
         end
      endfunction

      // Drop every free slot idle longer than the limit, if a sweep is due.
      function int unsigned age_out();
         int unsigned n;
         n = 0;
         if (!aging_en || idle_limit == 0) return 0;
         if (now_sec - last_sweep <= idle_limit) return 0;
         last_sweep = now_sec;
         for (int i = 0; i < POOL_SLOTS; i++) begin
            if (slot_valid[i] && !slot_busy[i] && (now_sec - idle_since[i]) > idle_limit) begin
               slot_valid[i] = 1'b0;
               n++;
            end
         end
         return n;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int      best;
         int      empty;
         int      h;
         h = int'(r.slot_handle);
         e.granted_slot   = r.slot_handle;
         e.granted_size   = '0;
         e.status         = ST_OTHER;
         e.slot_busy_flag = 1'b0;
         e.dropped_total  = '0;
         if (r.command == CMD_ALLOC) begin
            best = -1;
            for (int i = 0; i < POOL_SLOTS; i++) begin
               if (slot_valid[i] && !slot_busy[i] && slot_size[i] >= r.request_size &&
                   (best < 0 || slot_size[i] < slot_size[best]))
                  best = i;
            end
            if (best >= 0) begin
               slot_busy[best] = 1'b1;
               busy_count++;
               e.granted_slot = HANDLE_W'(best);
               e.granted_size = slot_size[best];
               e.status       = ST_REUSED;
            end else begin
               empty = -1;
               for (int i = 0; i < POOL_SLOTS && empty < 0; i++)
                  if (!slot_valid[i]) empty = i;
               if (empty >= 0) begin
                  slot_valid[empty] = 1'b1;
                  slot_busy[empty]  = 1'b1;
                  slot_size[empty]  = r.request_size;
                  busy_count++;
                  e.granted_slot  = HANDLE_W'(empty);
                  e.granted_size  = r.request_size;
                  e.status        = ST_NEW;
                  e.dropped_total = TOTAL_W'(age_out());
               end else begin
                  // pool full: nothing moves
                  e.granted_slot = '0;
                  e.status       = ST_FULL;
               end
            end
         end else begin
            if (slot_valid[h]) e.granted_size = slot_size[h];
            case (r.command)
               CMD_RELEASE: begin
                  if (slot_valid[h] && slot_busy[h]) begin
                     slot_busy[h] = 1'b0;
                     if (busy_count > 0) busy_count--;
                     idle_since[h] = now_sec;
                  end
               end
               CMD_QUERY: e.slot_busy_flag = slot_valid[h] && slot_busy[h];
               CMD_TICK:  now_sec++;
               CMD_CLEAR: begin
                  for (int i = 0; i < POOL_SLOTS; i++) begin
                     slot_valid[i] = 1'b0;
                     slot_busy[i]  = 1'b0;
                  end
                  busy_count     = 0;
                  aging_en       = 1'b0;
                  e.granted_size = '0;
               end
               default: ;
            endcase
         end
         e.busy_total = busy_count[TOTAL_W-1:0];
         owed_grants = {owed_grants, e};
      endfunction

      function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
         if (act !== exp) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp, act);
            errors++;
         end
      endfunction

      function void check_grant(rsp_type a);
         rsp_type e;
         if (owed_grants.size() == 0) begin
            $error("response beat with nothing owed: 0x%0h", a);
            errors++;
            return;
         end
         e = owed_grants.pop_front();
         compare_field("granted_slot",   e.granted_slot,   a.granted_slot);
         compare_field("granted_size",   e.granted_size,   a.granted_size);
         compare_field("status",         e.status,         a.status);
         compare_field("slot_busy_flag", e.slot_busy_flag, a.slot_busy_flag);
         compare_field("busy_total",     e.busy_total,     a.busy_total);
         compare_field("dropped_total",  e.dropped_total,  a.dropped_total);
      endfunction

      function int owed();
         return owed_grants.size();
      endfunction

      // Prefer a slot that is in use so releases and queries hit live state.
      function logic [HANDLE_W-1:0] pick_handle(int busy_pct);
         int live [$];
         for (int i = 0; i < POOL_SLOTS; i++)
            if (slot_valid[i] && slot_busy[i]) live = {live, i};
         if (live.size() > 0 && $urandom_range(0, 99) < busy_pct)
            return HANDLE_W'(live[$urandom_range(0, live.size() - 1)]);
         return HANDLE_W'($urandom_range(0, POOL_SLOTS - 1));
      endfunction
   endclass

   // ------------------------------------------------------------------
   // DUT hookup; every input is known from time zero.
   // ------------------------------------------------------------------
   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pool_shadow shadow = new();

   buffer_pool_best_fit_allocator #(
      .POOL_SLOTS(POOL_SLOTS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #TIMEOUT_NS;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ------------------------------------------------------------------
   // Response side: check every accepted beat, then pick the next ready.
   // The stall pattern switches between modes at random: always
   // ready, coin flip, or mostly ready with long stalls now and then.
   // ------------------------------------------------------------------
   int stall_mode = 0;
   int mode_left  = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) shadow.check_grant(rsp_data);
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(100, 400);
      end else begin
         mode_left--;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: begin
               // mostly ready; start a long stall once in a while
               if ($urandom_range(0, 15) == 0) begin
                  stall_left = $urandom_range(1, 50);
                  rsp_ready <= 1'b0;
               end else begin
                  rsp_ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Request side helpers. All calls start and end on a rising edge.
   // ------------------------------------------------------------------

   // Hold the beat until the block takes it, then note it in the shadow.
   task automatic send_item(req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      shadow.note_request(item);
   endtask

   // Drop valid for a gap; zero keeps the next beat back to back.
   task automatic idle_gap(int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Wait until every owed beat has come back and the block sits idle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (shadow.owed() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      shadow.write_reg(idx, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type make_req(logic [CMD_W-1:0] cmd, logic [SIZE_W-1:0] size,
                                        logic [HANDLE_W-1:0] handle);
      req_type r;
      r.command      = cmd;
      r.request_size = size;
      r.slot_handle  = handle;
      return r;
   endfunction

   // Sizes cluster on a few values so best-fit ties and reuse come up often.
   function automatic logic [SIZE_W-1:0] pick_size();
      int w;
      w = $urandom_range(0, 99);
      if (w < 40) return $urandom_range(0, 7);
      if (w < 60) return 32'd16 << (2 * $urandom_range(0, 4));
      if (w < 85) return $urandom;
      if (w < 95) return 32'hFFFF_FFFF - $urandom_range(0, 3);
      return '0;
   endfunction

   function automatic req_type random_req(int release_w);
      int      w;
      req_type r;
      w = $urandom_range(0, 99);
      r = make_req(CMD_ALLOC, pick_size(), HANDLE_W'($urandom_range(0, POOL_SLOTS - 1)));
      if (w < 35) begin
         r.command = CMD_ALLOC;
      end else if (w < 35 + release_w) begin
         r.command     = CMD_RELEASE;
         r.slot_handle = shadow.pick_handle(75);
      end else if (w < 45 + release_w) begin
         r.command     = CMD_QUERY;
         r.slot_handle = shadow.pick_handle(50);
      end else if (w < 65 + release_w) begin
         r.command = CMD_TICK;
      end else if (w < 66 + release_w) begin
         r.command = CMD_CLEAR;
      end else if (w < 69 + release_w) begin
         r.command = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      logic [SIZE_W-1:0]     dir_sizes [16];
      logic [CSR_DATA_W-1:0] limit;
      logic [CSR_DATA_W-1:0] en_word;
      int                    release_w;
      int                    burst_left;

      dir_sizes = '{32'd0, 32'hFFFF_FFFF, 32'd100, 32'd50, 32'd100, 32'd200, 32'd7, 32'd7,
                    32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd8, 32'd9};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty query, fill the pool, hit full, release with a
      // size tie, release twice, query both states, best-fit reuse, tick,
      // a reserved command and clear all.
      send_item(make_req(CMD_QUERY, $urandom, 4'd0));
      foreach (dir_sizes[i]) send_item(make_req(CMD_ALLOC, dir_sizes[i], HANDLE_W'($urandom)));
      send_item(make_req(CMD_ALLOC, 32'd10, 4'd0));
      send_item(make_req(CMD_RELEASE, $urandom, 4'd2));
      send_item(make_req(CMD_RELEASE, $urandom, 4'd4));
      send_item(make_req(CMD_RELEASE, $urandom, 4'd2));
      send_item(make_req(CMD_QUERY, $urandom, 4'd2));
      send_item(make_req(CMD_QUERY, $urandom, 4'd15));
      send_item(make_req(CMD_ALLOC, 32'd60, 4'd9));
      send_item(make_req(CMD_TICK, 32'hFFFF_FFFF, 4'd15));
      send_item(make_req(CMD_RSVD_LAST, 32'hFFFF_FFFF, 4'd15));
      send_item(make_req(CMD_CLEAR, $urandom, 4'd5));
      drain();

      // Random phases, each under its own aging setting.
      for (int p = 0; p < PHASES; p++) begin
         case (p == 0 ? 0 : p == 1 ? 5 : $urandom_range(0, 5))
            0: limit = '0;
            1: limit = 32'd1;
            2: limit = $urandom_range(2, 6);
            3: limit = $urandom_range(7, 40);
            4: limit = $urandom;
            default: limit = 32'hFFFF_FFFF;
         endcase
         write_csr(REG_TIMEOUT, limit);
         if (p == 2 || $urandom_range(0, 9) < 6) begin
            en_word    = $urandom;
            en_word[0] = (p == 2) ? 1'b0 : ($urandom_range(0, 9) < 7);
            write_csr(REG_DROP_EN, en_word);
         end

         release_w  = $urandom_range(15, 30);
         burst_left = 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_item(random_req(release_w));
            // bursts of back-to-back beats, then a random gap
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40));
            end else begin
               burst_left--;
            end
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (shadow.errors == 0 && shadow.owed() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
